>>> hdl/dpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpc_pkg;

    // Request codes
    localparam logic CMD_EXTEND = 1'b0;
    localparam logic CMD_FAULT  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd1;
    localparam logic [1:0] ST_NO_BLOCK  = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Fill codes
    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ZERO = 2'd1;
    localparam logic [1:0] FILL_DISK = 2'd2;

    // Configuration register indexes
    localparam logic REG_FRAMES = 1'b0;
    localparam logic REG_BLOCKS = 1'b1;

    typedef struct packed {
        logic       command;
        logic [1:0] process;
        logic [7:0] page_index;
        logic       write_access;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] new_page_index;
        logic [5:0] frame;
        logic [1:0] fill_kind;
        logic [9:0] read_block;
        logic       writeback;
        logic [9:0] writeback_block;
        logic       rd_grant;
        logic       wr_grant;
    } t_result;

    // Clock queue control
    typedef struct packed {
        logic push;
        logic pop;
        logic rotate;
    } t_q_ctl;

endpackage

`default_nettype wire

>>> hdl/dpc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dpc_cell
    import dpc_pkg::*;
#(
    parameter int IDW = 10
) (
    input  wire logic           i_clk,
    input  wire t_q_ctl         i_ctl,
    input  wire logic           i_is_tail,
    input  wire logic           i_is_slot,
    input  wire logic [IDW-1:0] i_push_id,
    input  wire logic [IDW-1:0] i_right,
    input  wire logic [IDW-1:0] i_head,
    output logic      [IDW-1:0] o_id
);

    logic [IDW-1:0] r_id;

    // Take the new page at the tail slot, shift on pop, wrap the head on rotate
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && i_is_slot) begin
            r_id <= i_push_id;
        end else if (i_ctl.pop) begin
            r_id <= i_right;
        end else if (i_ctl.rotate) begin
            r_id <= i_is_tail ? i_head : i_right;
        end
    end

    assign o_id = r_id;

endmodule

`default_nettype wire

>>> hdl/dpc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dpc_queue
    import dpc_pkg::*;
#(
    parameter int FRAMES = 64,
    parameter int IDW    = 10
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_q_ctl         i_ctl,
    input  wire logic [IDW-1:0] i_push_id,
    output logic      [IDW-1:0] o_head
);

    localparam int CW = $clog2(FRAMES + 1);

    logic [CW-1:0]  r_count;
    logic [IDW-1:0] s_id [FRAMES];

    // Track the number of live cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.push) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctl.pop) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Row of cells, head at cell zero
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        logic [IDW-1:0] s_right;
        if (g == FRAMES - 1) begin : g_last
            assign s_right = s_id[g];
        end else begin : g_mid
            assign s_right = s_id[g+1];
        end
        dpc_cell #(.IDW(IDW)) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_is_tail (32'(r_count) == g + 1),
            .i_is_slot (32'(r_count) == g),
            .i_push_id (i_push_id),
            .i_right   (s_right),
            .i_head    (s_id[0]),
            .o_id      (s_id[g])
        );
    end

    assign o_head = s_id[0];

endmodule

`default_nettype wire

>>> hdl/dpc_page_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module dpc_page_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 22,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/demand_pager_clock_replacement_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                                   Transfer
// request    i_start, o_busy, i_cmd                  i_start high while o_busy low
// result     o_done, o_result                        o_done high for one cycle
// config     i_cfg_we, i_cfg_index, i_cfg_data       i_cfg_we high
//
// An extend or refused request ends in the decode state; a fault on a resident page ends
// after the entry check; other faults fill a free frame or, with none free, read and check
// the clock head, passing referenced pages (at most the resident count), then evict and fill.
// The page table memory, with one read port and a registered read, sets the eviction pace.
// Synchronous active-low reset; no clearing pass. The result cannot be stalled.

module demand_pager_clock_replacement_top
    import dpc_pkg::*;
#(
    parameter int PROCESSES       = 4,
    parameter int PAGES_PER_ARENA = 256,
    parameter int FRAMES          = 64,
    parameter int N_BLOCKS        = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire t_cmd        i_cmd,
    output logic             o_done,
    output t_result          o_result,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);

    localparam int NPAGES = PROCESSES * PAGES_PER_ARENA;
    localparam int IDW    = (NPAGES > 1) ? $clog2(NPAGES) : 1;
    localparam int PXW    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int PW     = $clog2(PAGES_PER_ARENA + 1);
    localparam int FW     = $clog2(FRAMES + 1);
    localparam int FRW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int BW     = $clog2(N_BLOCKS + 1);
    localparam int BKW    = (N_BLOCKS > 1) ? $clog2(N_BLOCKS) : 1;

    typedef struct packed {
        logic [BKW-1:0] block;
        logic [FRW-1:0] frame;
        logic           dirty;
        logic           zero;
        logic           resident;
        logic           reference;
        logic           rd;
        logic           wr;
    } t_page;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_F_CHK, S_E_RD, S_E_CHK, S_FILL
    } t_state;

    t_state         r_state;
    t_cmd           r_cmd;
    logic [6:0]     r_cfg_frames;
    logic [10:0]    r_cfg_blocks;
    logic [PW-1:0]  r_ppp [PROCESSES];
    logic [FW-1:0]  r_fho;
    logic [BW-1:0]  r_bho;
    logic [IDW-1:0] r_id;
    t_page          r_entry;
    logic [FRW-1:0] r_fr;
    logic           r_wb;
    logic [BKW-1:0] r_wblk;

    logic [FW-1:0]  s_nf;
    logic [BW-1:0]  s_nb;
    logic           s_proc_ok;
    logic [PXW-1:0] s_pidx;
    logic [PW-1:0]  s_ppp;
    logic [IDW-1:0] s_fid;
    logic [IDW-1:0] s_eid;
    logic           s_we;
    logic [IDW-1:0] s_waddr;
    logic [IDW-1:0] s_raddr;
    t_page          s_wdata;
    t_page          s_rdata;
    t_q_ctl         s_qctl;
    logic [IDW-1:0] s_head;
    t_result        s_res;
    logic           s_wr_fault;

    // Clamp the configuration registers
    always_comb begin
        if (r_cfg_frames == 7'd0) begin
            s_nf = FW'(1);
        end else if (32'(r_cfg_frames) > FRAMES) begin
            s_nf = FW'(FRAMES);
        end else begin
            s_nf = FW'(r_cfg_frames);
        end
        s_nb = (32'(r_cfg_blocks) > N_BLOCKS) ? BW'(N_BLOCKS) : BW'(r_cfg_blocks);
    end

    assign s_proc_ok  = 32'(r_cmd.process) < PROCESSES;
    assign s_pidx     = PXW'(r_cmd.process);
    assign s_ppp      = r_ppp[s_pidx];
    assign s_fid      = IDW'(int'(r_cmd.process) * PAGES_PER_ARENA + int'(r_cmd.page_index));
    assign s_eid      = IDW'(int'(r_cmd.process) * PAGES_PER_ARENA + int'(s_ppp));
    assign s_wr_fault = r_cmd.write_access;

    // Drive page table and clock queue controls
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_id;
        s_wdata = s_rdata;
        s_raddr = s_head;
        s_qctl  = '0;
        case (r_state)
            S_DEC: begin
                s_raddr = s_fid;
                if (s_proc_ok && r_cmd.command == CMD_EXTEND && r_bho < s_nb
                        && 32'(s_ppp) < PAGES_PER_ARENA) begin
                    s_we          = 1'b1;
                    s_waddr       = s_eid;
                    s_wdata       = '0;
                    s_wdata.block = BKW'(s_nb - BW'(1) - r_bho);
                    s_wdata.zero  = 1'b1;
                end
            end
            S_F_CHK: begin
                if (s_rdata.resident) begin
                    s_we              = 1'b1;
                    s_wdata.reference = 1'b1;
                    s_wdata.rd        = 1'b1;
                    if (s_wr_fault || s_rdata.dirty) begin
                        s_wdata.wr    = 1'b1;
                        s_wdata.dirty = 1'b1;
                        s_wdata.zero  = 1'b0;
                    end
                end
            end
            S_E_CHK: begin
                s_we              = 1'b1;
                s_waddr           = s_head;
                s_wdata.reference = 1'b0;
                s_wdata.rd        = 1'b0;
                s_wdata.wr        = 1'b0;
                if (s_rdata.reference) begin
                    s_qctl.rotate = 1'b1;
                end else begin
                    s_qctl.pop        = 1'b1;
                    s_wdata.resident  = 1'b0;
                    s_wdata.frame     = '0;
                    s_wdata.dirty     = 1'b0;
                end
            end
            S_FILL: begin
                s_we              = 1'b1;
                s_qctl.push       = 1'b1;
                s_wdata           = r_entry;
                s_wdata.frame     = r_fr;
                s_wdata.resident  = 1'b1;
                s_wdata.reference = 1'b1;
                s_wdata.rd        = 1'b1;
                if (s_wr_fault || r_entry.dirty) begin
                    s_wdata.wr    = 1'b1;
                    s_wdata.dirty = 1'b1;
                    s_wdata.zero  = 1'b0;
                end
            end
            default: begin
                s_we = 1'b0;
            end
        endcase
    end

    // Build the result of the current state
    always_comb begin
        s_res = '0;
        case (r_state)
            S_DEC: begin
                if (!s_proc_ok) begin
                    s_res.status = ST_NOT_ALLOC;
                end else if (r_cmd.command == CMD_EXTEND) begin
                    if (r_bho >= s_nb) begin
                        s_res.status = ST_NO_BLOCK;
                    end else if (32'(s_ppp) >= PAGES_PER_ARENA) begin
                        s_res.status = ST_FULL;
                    end else begin
                        s_res.new_page_index = 8'(s_ppp);
                    end
                end else begin
                    s_res.status = ST_NOT_ALLOC;
                end
            end
            S_F_CHK: begin
                s_res.frame    = 6'(s_rdata.frame);
                s_res.rd_grant = 1'b1;
                s_res.wr_grant = s_wr_fault || s_rdata.dirty;
            end
            S_FILL: begin
                s_res.frame           = 6'(r_fr);
                s_res.fill_kind       = r_entry.zero ? FILL_ZERO : FILL_DISK;
                s_res.read_block      = r_entry.zero ? 10'd0 : 10'(r_entry.block);
                s_res.writeback       = r_wb;
                s_res.writeback_block = 10'(r_wblk);
                s_res.rd_grant        = 1'b1;
                s_res.wr_grant        = s_wr_fault || r_entry.dirty;
            end
            default: begin
                s_res = '0;
            end
        endcase
    end

    // Sequence one request at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_frames <= 7'd64;
            r_cfg_blocks <= 11'd1024;
            r_fho        <= '0;
            r_bho        <= '0;
            o_done       <= 1'b0;
            for (int p = 0; p < PROCESSES; p++) begin
                r_ppp[p] <= '0;
            end
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FRAMES) begin
                    r_cfg_frames <= i_cfg_data[6:0];
                end else begin
                    r_cfg_blocks <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_id <= s_fid;
                    if (s_proc_ok && r_cmd.command == CMD_FAULT
                            && 32'(r_cmd.page_index) < 32'(s_ppp)) begin
                        r_state <= S_F_CHK;
                    end else begin
                        if (s_proc_ok && r_cmd.command == CMD_EXTEND && r_bho < s_nb
                                && 32'(s_ppp) < PAGES_PER_ARENA) begin
                            r_ppp[s_pidx] <= s_ppp + PW'(1);
                            r_bho         <= r_bho + BW'(1);
                        end
                        o_result <= s_res;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_F_CHK: begin
                    r_entry <= s_rdata;
                    r_wb    <= 1'b0;
                    r_wblk  <= '0;
                    if (s_rdata.resident) begin
                        o_result <= s_res;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_fho < s_nf) begin
                        r_fr    <= FRW'(s_nf - FW'(1) - r_fho);
                        r_fho   <= r_fho + FW'(1);
                        r_state <= S_FILL;
                    end else begin
                        r_state <= S_E_RD;
                    end
                end
                S_E_RD: begin
                    r_state <= S_E_CHK;
                end
                S_E_CHK: begin
                    if (s_rdata.reference) begin
                        r_state <= S_E_RD;
                    end else begin
                        r_fr    <= s_rdata.frame;
                        r_wb    <= s_rdata.dirty;
                        r_wblk  <= s_rdata.dirty ? s_rdata.block : '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    o_result <= s_res;
                    o_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

    dpc_page_mem #(
        .DEPTH (NPAGES),
        .WIDTH ($bits(t_page))
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    dpc_queue #(
        .FRAMES (FRAMES),
        .IDW    (IDW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (s_qctl),
        .i_push_id (r_id),
        .o_head    (s_head)
    );

endmodule

`default_nettype wire

>>> hdl/dpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dpc_checker
    import dpc_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_start,
    input wire logic    o_busy,
    input wire logic    o_done,
    input wire t_result o_result
);

    // Accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request transfer did not raise busy");

    // Result comes when the block goes idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result while busy");

    // Refused request carries no frame or fill
    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |->
        (o_result.frame == 6'd0 && o_result.fill_kind == FILL_NONE
         && !o_result.rd_grant))
        else $error("refused request with payload");

    // Disk read block only with disk fill
    a_read_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.fill_kind != FILL_DISK) |-> o_result.read_block == 10'd0)
        else $error("read block without disk fill");

    // Write-back block only with write-back
    a_wb_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.writeback) |-> o_result.writeback_block == 10'd0)
        else $error("write-back block without write-back");

endmodule

bind demand_pager_clock_replacement_top dpc_checker u_dpc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
